// File: rtl/core/cct_pkg.sv
// ----------------------------------------------------------------------------
// cct_pkg
// Shared types, byte codes and date helpers for the CSV cell type classifier.
// ----------------------------------------------------------------------------
package cct_pkg;

   localparam int CHAR_W  = 8;
   localparam int INDEX_W = 8;
   localparam int LEN_W   = 4;

   localparam logic [CHAR_W-1:0] CHAR_NEWLINE    = 8'd10;
   localparam logic [CHAR_W-1:0] CHAR_PLUS       = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_COMMA      = 8'h2C;
   localparam logic [CHAR_W-1:0] CHAR_MINUS      = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_DOT        = 8'h2E;
   localparam logic [CHAR_W-1:0] CHAR_ZERO       = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE       = 8'h39;
   localparam logic [CHAR_W-1:0] SEPARATOR_RESET = 8'h3B;

   localparam logic [LEN_W-1:0] LEN_MAX   = 4'd15;
   localparam logic [LEN_W-1:0] DATE_LEN  = 4'd10;
   localparam logic [LEN_W-1:0] DASH1_POS = 4'd4;
   localparam logic [LEN_W-1:0] DASH2_POS = 4'd7;

   localparam logic [INDEX_W-1:0] INDEX_MAX = 8'd255;

   typedef enum logic [1:0] {
      FT_DATE   = 2'd0,
      FT_NUMBER = 2'd1,
      FT_TEXT   = 2'd2
   } field_type_type;

   typedef struct packed {
      field_type_type        field_type;
      logic [INDEX_W-1:0]    field_index;
      logic                  line_end;
   } result_type;

   // true when the two bcd digits form a value divisible by 4
   function automatic logic bcd_pair_div4(input logic [3:0] tens, input logic [3:0] ones);
      logic even_ok;
      logic odd_ok;
      even_ok = (ones == 4'd0) || (ones == 4'd4) || (ones == 4'd8);
      odd_ok  = (ones == 4'd2) || (ones == 4'd6);
      return tens[0] ? odd_ok : even_ok;
   endfunction

   function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
      logic [4:0] days;
      case (month)
         4'd2:    days = leap ? 5'd29 : 5'd28;
         4'd4:    days = 5'd30;
         4'd6:    days = 5'd30;
         4'd9:    days = 5'd30;
         4'd11:   days = 5'd30;
         default: days = 5'd31;
      endcase
      return days;
   endfunction

   function automatic logic date_ok(input logic [15:0] year, input logic [7:0] month,
                                    input logic [7:0] day);
      logic [6:0] mon;
      logic [6:0] dd;
      logic       low_zero;
      logic       leap;
      mon      = 7'(month[7:4]) * 7'd10 + 7'(month[3:0]);
      dd       = 7'(day[7:4]) * 7'd10 + 7'(day[3:0]);
      low_zero = (year[7:0] == 8'h00);
      // century years are leap only when the upper pair is divisible by 4
      leap     = low_zero ? bcd_pair_div4(year[15:12], year[11:8])
                          : bcd_pair_div4(year[7:4], year[3:0]);
      if (mon < 7'd1 || mon > 7'd12 || dd < 7'd1) begin
         return 1'b0;
      end
      return dd <= 7'(month_days(mon[3:0], leap));
   endfunction

endpackage

// File: rtl/core/cct_ifs.sv
// ----------------------------------------------------------------------------
// cct channel interfaces
// Valid/ready channels for bytes in, classification words out and the
// separator register write.
// ----------------------------------------------------------------------------
interface cct_req_if;
   logic                        valid;
   logic                        ready;
   logic [cct_pkg::CHAR_W-1:0]  char_in;

   modport source (output valid, output char_in, input ready);
   modport sink   (input valid, input char_in, output ready);
endinterface

interface cct_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [1:0]                   field_type;
   logic [cct_pkg::INDEX_W-1:0]  field_index;
   logic                         line_end;

   modport source (output valid, output field_type, output field_index,
                   output line_end, input ready);
   modport sink   (input valid, input field_type, input field_index,
                   input line_end, output ready);
endinterface

interface cct_csr_if;
   logic                        valid;
   logic                        ready;
   logic [cct_pkg::CHAR_W-1:0]  data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/cct_field_tracker.sv
// ----------------------------------------------------------------------------
// cct_field_tracker
// Per-field shape tracking; classifies the open field when a separator or
// newline word arrives and updates the field position within the line.
// ----------------------------------------------------------------------------
module cct_field_tracker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        take,
   input  logic [cct_pkg::CHAR_W-1:0]  char_in,
   input  logic [cct_pkg::CHAR_W-1:0]  separator,
   output logic                        close,
   output cct_pkg::result_type         result
);
   import cct_pkg::*;

   logic [LEN_W-1:0]   length_ff, length_in;
   logic               first_ok_ff, first_ok_in;
   logic [1:0]         sep_cnt_ff, sep_cnt_in;
   logic               num_bad_ff, num_bad_in;
   logic               shape_ok_ff, shape_ok_in;
   logic [15:0]        year_ff, year_in;
   logic [7:0]         month_ff, month_in;
   logic [7:0]         day_ff, day_in;
   logic [INDEX_W-1:0] index_ff, index_in;

   logic               newline;
   logic               digit;
   logic               is_dot;
   logic [3:0]         value;
   logic               number_ok;
   logic               is_date;

   assign newline = (char_in == CHAR_NEWLINE);
   assign close   = newline || (char_in == separator);
   assign digit   = (char_in >= CHAR_ZERO) && (char_in <= CHAR_NINE);
   assign is_dot  = (char_in == CHAR_DOT) || (char_in == CHAR_COMMA);
   assign value   = char_in[3:0];

   assign number_ok = (length_ff != '0) && first_ok_ff && (sep_cnt_ff <= 2'd1) && !num_bad_ff;
   assign is_date   = (length_ff == DATE_LEN) && shape_ok_ff
                      && date_ok(year_ff, month_ff, day_ff);

   always_comb begin
      result.field_type  = is_date ? FT_DATE : (number_ok ? FT_NUMBER : FT_TEXT);
      result.field_index = index_ff;
      result.line_end    = newline;
   end

   always_comb begin
      length_in   = length_ff;
      first_ok_in = first_ok_ff;
      sep_cnt_in  = sep_cnt_ff;
      num_bad_in  = num_bad_ff;
      shape_ok_in = shape_ok_ff;
      year_in     = year_ff;
      month_in    = month_ff;
      day_in      = day_ff;
      index_in    = index_ff;
      if (take && close) begin
         length_in   = '0;
         first_ok_in = 1'b0;
         sep_cnt_in  = '0;
         num_bad_in  = 1'b0;
         shape_ok_in = 1'b1;
         year_in     = '0;
         month_in    = '0;
         day_in      = '0;
         if (newline) begin
            index_in = '0;
         end else if (index_ff != INDEX_MAX) begin
            index_in = index_ff + 1'b1;
         end
      end else if (take) begin
         // number shape
         if (length_ff == '0) begin
            first_ok_in = digit || (char_in == CHAR_PLUS) || (char_in == CHAR_MINUS);
         end else if (is_dot) begin
            if (sep_cnt_ff != 2'd2) begin
               sep_cnt_in = sep_cnt_ff + 1'b1;
            end
         end else if (!digit) begin
            num_bad_in = 1'b1;
         end
         // date shape, YYYY-MM-DD
         if (length_ff < DATE_LEN) begin
            if (length_ff == DASH1_POS || length_ff == DASH2_POS) begin
               if (char_in != CHAR_MINUS) begin
                  shape_ok_in = 1'b0;
               end
            end else if (!digit) begin
               shape_ok_in = 1'b0;
            end else if (length_ff < DASH1_POS) begin
               year_in = {year_ff[11:0], value};
            end else if (length_ff < DASH2_POS) begin
               month_in = {month_ff[3:0], value};
            end else begin
               day_in = {day_ff[3:0], value};
            end
         end else begin
            shape_ok_in = 1'b0;
         end
         if (length_ff != LEN_MAX) begin
            length_in = length_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff   <= '0;
         first_ok_ff <= 1'b0;
         sep_cnt_ff  <= '0;
         num_bad_ff  <= 1'b0;
         shape_ok_ff <= 1'b1;
         year_ff     <= '0;
         month_ff    <= '0;
         day_ff      <= '0;
         index_ff    <= '0;
      end else begin
         length_ff   <= length_in;
         first_ok_ff <= first_ok_in;
         sep_cnt_ff  <= sep_cnt_in;
         num_bad_ff  <= num_bad_in;
         shape_ok_ff <= shape_ok_in;
         year_ff     <= year_in;
         month_ff    <= month_in;
         day_ff      <= day_in;
         index_ff    <= index_in;
      end
   end

endmodule

// File: rtl/core/csv_cell_type_classifier.sv
// ----------------------------------------------------------------------------
// csv_cell_type_classifier
// Classifies each CSV field as date, number or text as its bytes stream in.
// ----------------------------------------------------------------------------
//   channel  dir  payload                              word
//   req      in   char_in                              one text byte
//   rsp      out  field_type, field_index, line_end    one closed field
//   csr      in   data                                 separator byte
//
// one byte per cycle while req is ready; a separator or newline byte gives its
// result in the cycle after acceptance, from the field state registers into the
// output register. req is ready whenever the output register is empty or being
// drained, so a stalled rsp blocks input only while a result is held.
// reset clears the field state and sets the separator to ';'. csr is always
// ready.
module csv_cell_type_classifier (
   input  logic       clock,
   input  logic       reset,
   cct_req_if.sink    req,
   cct_rsp_if.source  rsp,
   cct_csr_if.sink    csr
);
   import cct_pkg::*;

   logic [CHAR_W-1:0] separator_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_data_ff;
   logic              take;
   logic              close;
   result_type        result;

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign csr.ready = 1'b1;
   assign take      = req.valid && req.ready;

   cct_field_tracker u_tracker (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .char_in   (req.char_in),
      .separator (separator_ff),
      .close     (close),
      .result    (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take && close) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         separator_ff <= SEPARATOR_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr.valid) begin
            separator_ff <= csr.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take && close) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.field_type  = rsp_data_ff.field_type;
   assign rsp.field_index = rsp_data_ff.field_index;
   assign rsp.line_end    = rsp_data_ff.line_end;

   // newline always closes a field and marks the end of the line
   a_newline_result : assert property (@(posedge clock) disable iff (reset)
      take && req.char_in == CHAR_NEWLINE |=> rsp.valid && rsp.line_end)
      else $error("newline did not produce a line-end result");

   // an ordinary byte leaves the output register empty
   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      take && !close |=> !rsp.valid)
      else $error("result produced for a non-closing byte");

   // a separator that is not newline never marks the line end
   a_sep_not_end : assert property (@(posedge clock) disable iff (reset)
      take && close && req.char_in != CHAR_NEWLINE |=> rsp.valid && !rsp.line_end)
      else $error("separator result marked as line end");

endmodule
